/* sv/ctb_pkg.sv */
// ctb_pkg: shared types, codes and helpers of the cursor text buffer engine
// no dependencies; used by the interfaces, the cell, the cell row and the top level

package ctb_pkg;

  localparam int unsigned ACT_W  = 4;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned POS_W  = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_FWD        = 4'd0,
    ACT_BACK       = 4'd1,
    ACT_START      = 4'd2,
    ACT_END        = 4'd3,
    ACT_INSERT     = 4'd4,
    ACT_DEL_CHAR   = 4'd5,
    ACT_WORD_END   = 4'd6,
    ACT_WORD_START = 4'd7,
    ACT_DEL_WORD   = 4'd8,
    ACT_READ       = 4'd9
  } act_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK_FWD,
    ST_WALK_BACK,
    ST_WALK_DEL,
    ST_RESP
  } state_e;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_e            op;
    logic [CHAR_W-1:0]   ch;
  } cell_ctrl_t;

  // where a cell stands relative to the edit position
  typedef struct packed {
    logic at;
    logic past;
  } cell_sel_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
  endfunction

endpackage

/* sv/ctb_if.sv */
// ctb_in_if / ctb_out_if: valid-ready channels of the cursor text buffer engine
// depends on ctb_pkg for the field widths

interface ctb_in_if import ctb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [CHAR_W-1:0] char_in;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, action, char_in, read_index, input ready);
  modport sink   (input valid, action, char_in, read_index, output ready);
endinterface

interface ctb_out_if import ctb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_pos;
  logic [POS_W-1:0]  text_length;
  logic [CHAR_W-1:0] char_out;
  logic              full_drop;

  modport source (output valid, cursor_pos, text_length, char_out, full_drop, input ready);
  modport sink   (input valid, cursor_pos, text_length, char_out, full_drop, output ready);
endinterface

/* sv/ctb_cell.sv */
// ctb_cell: one character slot of the text row
// depends on ctb_pkg; takes its left or right neighbour on insert and delete shifts

module ctb_cell import ctb_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  cell_sel_t         sel_i,
  input  logic [CHAR_W-1:0] left_i,
  input  logic [CHAR_W-1:0] right_i,
  output logic [CHAR_W-1:0] char_o
);

  logic [CHAR_W-1:0] char_q, char_d;

  always_comb begin
    char_d = char_q;
    unique case (ctrl_i.op)
      CELL_INS: begin
        if (sel_i.at) begin
          char_d = ctrl_i.ch;
        end else if (sel_i.past) begin
          char_d = left_i;
        end
      end
      CELL_DEL: begin
        if (sel_i.at || sel_i.past) begin
          char_d = right_i;
        end
      end
      default: char_d = char_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign char_o = char_q;

endmodule

/* sv/ctb_row.sv */
// ctb_row: chain of character cells with one read select
// depends on ctb_pkg and ctb_cell

module ctb_row import ctb_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                       clk_i,
  input  cell_ctrl_t                 ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0] pos_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [CHAR_W-1:0]          rdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH+1);

  logic [CHAR_W-1:0] cell_char [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_sel_t         sel;
    logic [CHAR_W-1:0] left, right;

    assign sel.at   = (pos_i == PW'(i));
    assign sel.past = (pos_i <  PW'(i));

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_char[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_char[i+1];
    end

    ctb_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .sel_i   (sel),
      .left_i  (left),
      .right_i (right),
      .char_o  (cell_char[i])
    );
  end

  // one-hot and-or select of the addressed cell
  always_comb begin
    rdata_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (raddr_i == AW'(i)) begin
        rdata_o = rdata_o | cell_char[i];
      end
    end
  end

endmodule

/* sv/cursor_text_buffer_engine.sv */
// cursor_text_buffer_engine: line buffer with an edit cursor, top level
// depends on ctb_pkg, ctb_if (ctb_in_if, ctb_out_if) and ctb_row

// One word in, one word out. The text lives in a row of CAPACITY character cells;
// insert and delete move every cell after the cursor by one place all at once, so
// plain moves, insert, delete char and read pass through the accept, execute and
// respond states. Word end, word start and delete word walk one character per
// cycle through the row's read select; that walk sets the worst case. One word is
// handled at a time; a finished result sits in the output register while the next
// word is accepted. An insert into a full buffer leaves the text alone and raises
// full_drop. A read at or past the length returns 0. cursor_pos and text_length
// are the low 9 bits of the internal counts.

module cursor_text_buffer_engine import ctb_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  ctb_in_if.sink    in_i,
  ctb_out_if.source out_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = $clog2(CAPACITY+1);
  localparam int unsigned CW = (PW > IDX_W) ? PW : IDX_W;

  state_e            state_q, state_d;
  logic [PW-1:0]     cursor_q, cursor_d;
  logic [PW-1:0]     len_q, len_d;
  logic [ACT_W-1:0]  act_q;
  logic [CHAR_W-1:0] ch_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CHAR_W-1:0] rd_q, rd_d;
  logic              drop_q, drop_d;

  logic              out_valid_q;
  logic [POS_W-1:0]  out_cursor_q, out_len_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_drop_q;
  logic              out_load;

  cell_ctrl_t        cell_ctrl;
  logic [AW-1:0]     raddr;
  logic [CHAR_W-1:0] rdata;
  logic              not_end, at_start, blank_at, accept;

  ctb_row #(
    .DEPTH (CAPACITY)
  ) u_row (
    .clk_i   (clk_i),
    .ctrl_i  (cell_ctrl),
    .pos_i   (cursor_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign not_end    = (cursor_q < len_q);
  assign at_start   = (cursor_q == '0);
  assign blank_at   = is_blank(rdata);

  // read address: char before the cursor when walking back, read index on a read, else the char at the cursor
  always_comb begin
    if (state_q == ST_WALK_BACK) begin
      raddr = AW'(cursor_q - 1'b1);
    end else if ((state_q == ST_EXEC) && (act_e'(act_q) == ACT_READ)) begin
      raddr = AW'(idx_q);
    end else begin
      raddr = AW'(cursor_q);
    end
  end

  always_comb begin
    state_d      = state_q;
    cursor_d     = cursor_q;
    len_d        = len_q;
    rd_d         = rd_q;
    drop_d       = drop_q;
    cell_ctrl.op = CELL_HOLD;
    cell_ctrl.ch = ch_q;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_d    = '0;
          drop_d  = 1'b0;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_RESP;
        unique case (act_e'(act_q))
          ACT_FWD: begin
            if (not_end) cursor_d = cursor_q + 1'b1;
          end
          ACT_BACK: begin
            if (!at_start) cursor_d = cursor_q - 1'b1;
          end
          ACT_START: cursor_d = '0;
          ACT_END:   cursor_d = len_q;
          ACT_INSERT: begin
            if (len_q == PW'(CAPACITY)) begin
              drop_d = 1'b1;
            end else begin
              cell_ctrl.op = CELL_INS;
              cursor_d     = cursor_q + 1'b1;
              len_d        = len_q + 1'b1;
            end
          end
          ACT_DEL_CHAR: begin
            if (not_end) begin
              cell_ctrl.op = CELL_DEL;
              len_d        = len_q - 1'b1;
            end
          end
          ACT_WORD_END: begin
            if (not_end) cursor_d = cursor_q + 1'b1;
            state_d = ST_WALK_FWD;
          end
          ACT_WORD_START: begin
            if (!at_start) cursor_d = cursor_q - 1'b1;
            state_d = ST_WALK_BACK;
          end
          ACT_DEL_WORD: begin
            if (not_end) begin
              cell_ctrl.op = CELL_DEL;
              len_d        = len_q - 1'b1;
            end
            state_d = ST_WALK_DEL;
          end
          ACT_READ: begin
            if (CW'(idx_q) < CW'(len_q)) rd_d = rdata;
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_WALK_FWD: begin
        if (not_end && !blank_at) begin
          cursor_d = cursor_q + 1'b1;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_WALK_BACK: begin
        if (!at_start && !blank_at) begin
          cursor_d = cursor_q - 1'b1;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_WALK_DEL: begin
        if (not_end && !blank_at) begin
          cell_ctrl.op = CELL_DEL;
          len_d        = len_q - 1'b1;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        // wait until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      len_q    <= len_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // latched item and result payload
  always_ff @(posedge clk_i) begin
    rd_q   <= rd_d;
    drop_q <= drop_d;
    if (accept) begin
      act_q <= in_i.action;
      ch_q  <= in_i.char_in;
      idx_q <= in_i.read_index;
    end
    if (out_load) begin
      out_cursor_q <= POS_W'(cursor_q);
      out_len_q    <= POS_W'(len_q);
      out_char_q   <= rd_q;
      out_drop_q   <= drop_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.cursor_pos  = out_cursor_q;
  assign out_o.text_length = out_len_q;
  assign out_o.char_out    = out_char_q;
  assign out_o.full_drop   = out_drop_q;

  // cursor never passes the end of the text
  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= len_q)
    else $error("cursor beyond text length");

  // text never exceeds the row
  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= PW'(CAPACITY))
    else $error("text length beyond capacity");

  // a dropped insert only ever happens on a full buffer
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && drop_q |-> len_q == PW'(CAPACITY))
    else $error("insert dropped while buffer not full");

  // each cycle the word delete keeps going it removes one character
  a_walk_del_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK_DEL) && (state_d == ST_WALK_DEL) |=> len_q == $past(len_q) - 1'b1)
    else $error("word delete step did not shorten text");

  // a word is taken only in the idle state, and an accepted word moves on to execute
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted word not executed");

endmodule
